FILE: hdl/sha_pkg.sv
// ============================================================================
// sha_pkg
// Shared types, constants and the rotate function of the byte-stream hasher.
// ============================================================================
package sha_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } sha_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        last_word;
    } sha_out_t;

    // control from the sequencer to the round unit
    typedef struct packed {
        logic       start;
        logic       load_w;
        logic [3:0] w_index;
    } sha_ctl_t;

    localparam logic [7:0] PadByte = 8'h80;
    localparam int unsigned LenOffset = 56;

    localparam logic [31:0] InitHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RoundConst [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

FILE: hdl/sha_block_ram.sv
// ============================================================================
// sha_block_ram
// Message block buffer: 16 words of 32 bits, byte write enables, registered
// read.
// ============================================================================
module sha_block_ram (
    input  logic        aclk,
    input  logic        we,
    input  logic [3:0]  waddr,
    input  logic [3:0]  wbe,
    input  logic [31:0] wdata,
    input  logic [3:0]  raddr,
    output logic [31:0] rdata
);

    logic [31:0] mem [16];

    // byte-lane write, registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            for (int b = 0; b < 4; b++) begin
                if (wbe[b]) mem[waddr][8*b +: 8] <= wdata[8*b +: 8];
            end
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/sha_round_unit.sv
// ============================================================================
// sha_round_unit
// One compression round per cycle while run is high, with a 16-word schedule
// window and the chaining words.
// ============================================================================
module sha_round_unit
    import sha_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  sha_ctl_t    ctl,
    input  logic [31:0] w_in,
    input  logic        run,
    input  logic [5:0]  round,
    input  logic        finish,
    input  logic        reinit,
    input  logic [2:0]  rd_sel,
    output logic [31:0] chain_word
);

    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [31:0] h_reg [8];
    logic [31:0] w_cur, w_new, s0, s1, t1, t2;

    // schedule: window slot 0 is the word of this round
    always_comb begin
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = s1 + w_reg[9] + s0 + w_reg[0];
        w_cur = w_reg[0];
        t1 = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + RoundConst[round] + w_cur;
        t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    // schedule window load and shift
    always_ff @(posedge aclk) begin
        if (ctl.load_w) begin
            w_reg[ctl.w_index] <= w_in;
        end else if (run) begin
            for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
            w_reg[15] <= w_new;
        end
    end

    // working variables
    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
        end else if (run) begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    // chaining words
    always_ff @(posedge aclk) begin
        if (!aresetn || reinit) begin
            for (int i = 0; i < 8; i++) h_reg[i] <= InitHash[i];
        end else if (finish) begin
            for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
        end
    end

    assign chain_word = h_reg[rd_sel];

endmodule

FILE: hdl/sha256_byte_stream_hasher.sv
// ============================================================================
// sha256_byte_stream_hasher
// SHA-256 over a byte stream, eight digest words per finished message.
// ============================================================================
//  channel | ports           | payload
//  input   | s_valid/s_ready | sha_in_t: data_byte, byte_valid, end_of_message
//  output  | m_valid/m_ready | sha_out_t: digest_word, word_number, last_word
//
// a plain byte makes one write into the block buffer before the next item is taken
// a byte that fills a block adds the load of the 16-word schedule window, 64 rounds and one update
// a finishing item adds padding writes (up to 16 per block) plus one or two compressions
// then eight digest words go out, one per accepted output handshake
// synchronous active-low reset restores the initial hash and empties the block
module sha256_byte_stream_hasher
    import sha_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  sha_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output sha_out_t m_data
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_BYTE, ST_PAD, ST_LOAD, ST_ROUND, ST_FIN, ST_EMIT
    } state_t;

    state_t      state_reg;
    logic [5:0]  fill_reg;
    logic [5:0]  fill_next;
    logic [63:0] count_reg;
    logic        last_reg, second_reg;
    logic [4:0]  idx_reg;
    logic [5:0]  round_reg;
    logic [2:0]  word_reg;
    sha_in_t     item_reg;
    logic        finish_pad_done_reg;

    logic        we;
    logic [3:0]  waddr, wbe, raddr;
    logic [31:0] wdata, rdata, chain_word;
    sha_ctl_t    ctl;
    logic        run, finish, reinit;
    logic        ld_valid_reg;
    logic [3:0]  ld_idx_reg;

    // fill level after the byte of the current item
    assign fill_next = fill_reg + {5'b0, item_reg.byte_valid};

    // block buffer write port
    always_comb begin
        we = 1'b0; waddr = fill_reg[5:2]; wbe = '0; wdata = '0;
        case (state_reg)
            ST_BYTE: begin
                we = item_reg.byte_valid;
                wbe = 4'b1000 >> fill_reg[1:0];
                wdata = {4{item_reg.data_byte}};
            end
            ST_PAD: begin
                we = 1'b1;
                waddr = idx_reg[3:0];
                if (idx_reg[3:0] == fill_reg[5:2] && !second_reg) begin
                    // pad byte and zeros after the kept bytes of this word
                    wbe = 4'b1111 >> fill_reg[1:0];
                    wdata = {PadByte, 24'h0} >> (8 * fill_reg[1:0]);
                end else begin
                    wbe = 4'b1111;
                end
                if (!last_reg && idx_reg[3:0] == 4'd14) wdata = count_reg[63:32];
                if (!last_reg && idx_reg[3:0] == 4'd15) wdata = count_reg[31:0];
            end
            default: ;
        endcase
    end

    assign raddr = idx_reg[3:0];
    assign ctl.start = (state_reg == ST_LOAD) && (idx_reg == 5'd16);
    assign ctl.load_w = ld_valid_reg;
    assign ctl.w_index = ld_idx_reg;
    assign run = (state_reg == ST_ROUND);
    assign finish = (state_reg == ST_FIN);
    assign reinit = (state_reg == ST_EMIT) && m_ready && (word_reg == 3'd7);

    sha_block_ram u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wbe(wbe), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    sha_round_unit u_round (
        .aclk(aclk), .aresetn(aresetn), .ctl(ctl), .w_in(rdata), .run(run),
        .round(round_reg), .finish(finish), .reinit(reinit), .rd_sel(word_reg),
        .chain_word(chain_word)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_EMIT);
    assign m_data.digest_word = chain_word;
    assign m_data.word_number = word_reg;
    assign m_data.last_word = (word_reg == 3'd7);

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg <= '0;
            count_reg <= '0;
            ld_valid_reg <= 1'b0;
            idx_reg <= '0; round_reg <= '0; word_reg <= '0;
            last_reg <= 1'b0; second_reg <= 1'b0;
        end else begin
            ld_valid_reg <= (state_reg == ST_LOAD) && !idx_reg[4];
            ld_idx_reg <= idx_reg[3:0];
            case (state_reg)
                ST_IDLE: if (s_valid) begin
                    item_reg <= s_data;
                    state_reg <= ST_BYTE;
                end
                ST_BYTE: begin
                    second_reg <= 1'b0;
                    fill_reg <= fill_next;
                    if (item_reg.byte_valid) count_reg <= count_reg + 64'd8;
                    if (item_reg.byte_valid && fill_reg == 6'd63) begin
                        last_reg <= 1'b0;
                        idx_reg <= '0;
                        state_reg <= ST_LOAD;
                    end else if (item_reg.end_of_message) begin
                        // padding starts at the word that holds the pad byte
                        last_reg <= fill_next > 6'd55;
                        idx_reg <= {1'b0, fill_next[5:2]};
                        state_reg <= ST_PAD;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_PAD: begin
                    if (idx_reg[3:0] == 4'd15) begin
                        idx_reg <= '0;
                        state_reg <= ST_LOAD;
                    end else begin
                        idx_reg <= idx_reg + 5'd1;
                    end
                end
                ST_LOAD: begin
                    idx_reg <= idx_reg + 5'd1;
                    round_reg <= '0;
                    if (idx_reg == 5'd16) state_reg <= ST_ROUND;
                end
                ST_ROUND: begin
                    round_reg <= round_reg + 6'd1;
                    if (round_reg == 6'd63) state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    idx_reg <= '0;
                    word_reg <= '0;
                    if (last_reg) begin
                        // second final block: zeros then length
                        state_reg <= ST_PAD;
                        last_reg <= 1'b0;
                        second_reg <= 1'b1;
                    end else if (item_reg.end_of_message && !finish_pad_done_reg) begin
                        // block just filled by the finishing byte: pad fresh block
                        state_reg <= ST_PAD;
                        second_reg <= 1'b0;
                    end else if (item_reg.end_of_message) begin
                        state_reg <= ST_EMIT;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_EMIT: if (m_ready) begin
                    word_reg <= word_reg + 3'd1;
                    if (word_reg == 3'd7) begin
                        state_reg <= ST_IDLE;
                        fill_reg <= '0;
                        count_reg <= '0;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // marks that the padding pass of the current message has been written
    always_ff @(posedge aclk) begin
        if (!aresetn || state_reg == ST_IDLE) finish_pad_done_reg <= 1'b0;
        else if (state_reg == ST_PAD) finish_pad_done_reg <= 1'b1;
    end

    // digest words leave in order, and no input is taken while the result is offered
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last_word |=> m_data.word_number ==
        $past(m_data.word_number) + 3'd1)
        else $error("digest word order broken");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("input taken during digest output");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ROUND && round_reg == 6'd63 |=> state_reg == ST_FIN)
        else $error("round count slip");

endmodule
